[rtl/itrc_pkg.sv]
package itrc_pkg;

  localparam int MAX_PACKET_BYTES = 4096;
  localparam int IDX_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int MIN_PACKET       = 40;
  localparam int IP_VERSION       = 4;
  localparam int MIN_HDR_WORDS    = 5;
  localparam int TCP_PROTO        = 6;
  localparam int PAY_W            = 12;
  localparam int PAY_MAX          = (1 << PAY_W) - 1;
  localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

  // IP header byte offsets
  localparam int OFS_VER_IHL  = 0;
  localparam int OFS_PROTOCOL = 9;
  localparam int OFS_ADDR_LO  = 12;
  localparam int OFS_ADDR_HI  = 20;
  localparam int OFS_ADDR_END = 19;

  // TCP header byte offsets relative to the end of the IP header
  localparam int TCP_HDR0_END = 8;
  localparam int TCP_HDR1_END = 16;
  localparam int TCP_URG_HI   = 18;
  localparam int TCP_URG_LO   = 19;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_NOT_IPV4    = 3'd2,
    ST_NOT_TCP     = 3'd3,
    ST_BAD_IP_SUM  = 3'd4,
    ST_BAD_TCP_SUM = 3'd5,
    ST_TOO_LONG    = 3'd6
  } status_t;

  // Packet state frozen at the last byte
  typedef struct packed {
    logic [IDX_W-1:0] count;
    logic [3:0]       ip_hw;
    logic [15:0]      ip_sum;
    logic [15:0]      tcp_sum;
    logic             version_ok;
    logic             protocol_ok;
    logic             too_long;
    logic [63:0]      addresses;
    logic [63:0]      hdr0;
    logic [63:0]      hdr1;
    logic [15:0]      urgent;
  } snap_t;

  typedef struct packed {
    status_t          status;
    logic [31:0]      source_address;
    logic [31:0]      dest_address;
    logic [15:0]      source_port;
    logic [15:0]      dest_port;
    logic [31:0]      sequence_number;
    logic [31:0]      ack_number;
    logic [3:0]       header_words;
    logic [8:0]       control_bits;
    logic [15:0]      window_size;
    logic [15:0]      urgent_pointer;
    logic [PAY_W-1:0] payload_length;
  } res_t;

endpackage

[rtl/itrc_parse.sv]
module itrc_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  output logic                snap_valid,
  input  logic                snap_ready,
  output itrc_pkg::snap_t     snap
);

  localparam int IDX_W = itrc_pkg::IDX_W;

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_last;
  logic             take;

  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [3:0]       ip_hw, ip_hw_next;
  logic [15:0]      ip_sum, ip_sum_next;
  logic [15:0]      tcp_sum, tcp_sum_next;
  logic             version_ok, version_ok_next;
  logic             protocol_ok, protocol_ok_next;
  logic [63:0]      addresses, addresses_next;
  logic [63:0]      hdr0, hdr0_next;
  logic [63:0]      hdr1, hdr1_next;
  logic [15:0]      urgent, urgent_next;
  logic             too_long, too_long_next;

  logic [3:0]       ihl_eff;
  logic [5:0]       hl;
  logic [IDX_W-1:0] rel;
  logic [15:0]      word;
  logic [2:0]       addr_pos;

  function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // A last byte needs the snapshot register free; other bytes always drain
  assign take     = in_valid && (!in_last || !snap_valid || snap_ready);
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_comb begin
    byte_index_next  = byte_index;
    ip_hw_next       = ip_hw;
    ip_sum_next      = ip_sum;
    tcp_sum_next     = tcp_sum;
    version_ok_next  = version_ok;
    protocol_ok_next = protocol_ok;
    addresses_next   = addresses;
    hdr0_next        = hdr0;
    hdr1_next        = hdr1;
    urgent_next      = urgent;
    too_long_next    = too_long;

    ihl_eff  = (byte_index == IDX_W'(itrc_pkg::OFS_VER_IHL)) ? in_byte[3:0] : ip_hw;
    hl       = {ihl_eff, 2'b00};
    rel      = byte_index - IDX_W'(hl);
    word     = byte_index[0] ? {8'h00, in_byte} : {in_byte, 8'h00};
    addr_pos = 3'(5'(itrc_pkg::OFS_ADDR_END) - byte_index[4:0]);

    if (byte_index == IDX_W'(itrc_pkg::MAX_PACKET_BYTES)) begin
      // drop bytes past the limit
      too_long_next = 1'b1;
    end else begin
      byte_index_next = byte_index + 1'b1;
      if (byte_index == IDX_W'(itrc_pkg::OFS_VER_IHL)) begin
        ip_hw_next      = in_byte[3:0];
        version_ok_next = (in_byte[7:4] == 4'(itrc_pkg::IP_VERSION)) &&
                          (in_byte[3:0] >= 4'(itrc_pkg::MIN_HDR_WORDS));
      end
      if (byte_index == IDX_W'(itrc_pkg::OFS_PROTOCOL)) begin
        protocol_ok_next = (in_byte == 8'(itrc_pkg::TCP_PROTO));
      end
      if (byte_index >= IDX_W'(itrc_pkg::OFS_ADDR_LO) &&
          byte_index <  IDX_W'(itrc_pkg::OFS_ADDR_HI)) begin
        addresses_next[{addr_pos, 3'b000} +: 8] = in_byte;
      end
      if (byte_index < IDX_W'(hl)) begin
        ip_sum_next = fold_add(ip_sum, word);
      end else begin
        tcp_sum_next = fold_add(tcp_sum, word);
        if (rel < IDX_W'(itrc_pkg::TCP_HDR0_END)) begin
          hdr0_next[{~rel[2:0], 3'b000} +: 8] = in_byte;
        end else if (rel < IDX_W'(itrc_pkg::TCP_HDR1_END)) begin
          hdr1_next[{~rel[2:0], 3'b000} +: 8] = in_byte;
        end else if (rel == IDX_W'(itrc_pkg::TCP_URG_HI)) begin
          urgent_next[15:8] = in_byte;
        end else if (rel == IDX_W'(itrc_pkg::TCP_URG_LO)) begin
          urgent_next[7:0] = in_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && in_last)) begin
      byte_index  <= '0;
      ip_hw       <= '0;
      ip_sum      <= '0;
      tcp_sum     <= '0;
      version_ok  <= 1'b0;
      protocol_ok <= 1'b0;
      addresses   <= '0;
      hdr0        <= '0;
      hdr1        <= '0;
      urgent      <= '0;
      too_long    <= 1'b0;
    end else if (take) begin
      byte_index  <= byte_index_next;
      ip_hw       <= ip_hw_next;
      ip_sum      <= ip_sum_next;
      tcp_sum     <= tcp_sum_next;
      version_ok  <= version_ok_next;
      protocol_ok <= protocol_ok_next;
      addresses   <= addresses_next;
      hdr0        <= hdr0_next;
      hdr1        <= hdr1_next;
      urgent      <= urgent_next;
      too_long    <= too_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (take && in_last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
    if (take && in_last) begin
      snap.count       <= byte_index_next;
      snap.ip_hw       <= ip_hw_next;
      snap.ip_sum      <= ip_sum_next;
      snap.tcp_sum     <= tcp_sum_next;
      snap.version_ok  <= version_ok_next;
      snap.protocol_ok <= protocol_ok_next;
      snap.too_long    <= too_long_next;
      snap.addresses   <= addresses_next;
      snap.hdr0        <= hdr0_next;
      snap.hdr1        <= hdr1_next;
      snap.urgent      <= urgent_next;
    end
  end

endmodule

[rtl/itrc_verify.sv]
module itrc_verify (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_valid,
  output logic            snap_ready,
  input  itrc_pkg::snap_t snap,
  output logic            m_tvalid,
  input  logic            m_tready,
  output itrc_pkg::res_t  res
);

  localparam int IDX_W = itrc_pkg::IDX_W;

  logic             out_ready;
  logic             mid_valid;
  itrc_pkg::res_t   mid_res, mid_res_next;
  logic             mid_check, mid_check_next;
  logic [17:0]      mid_addr_sum, mid_addr_sum_next;
  logic [IDX_W-1:0] mid_seg_len, mid_seg_len_next;
  logic [15:0]      mid_tcp_sum;

  logic [5:0]       hl;
  logic [5:0]       tl;
  logic [6:0]       hdr_len;
  logic [IDX_W-1:0] pay_full;
  logic [3:0]       hw;

  logic [19:0]      total;
  logic [16:0]      fold1;
  logic [15:0]      fold2;
  itrc_pkg::res_t   res_next;

  assign out_ready  = !m_tvalid || m_tready;
  assign snap_ready = !mid_valid || out_ready;

  // First half: field extraction, length checks, address sum
  always_comb begin
    hw       = snap.hdr1[31:28];
    hl       = {snap.ip_hw, 2'b00};
    tl       = {hw, 2'b00};
    hdr_len  = {1'b0, hl} + {1'b0, tl};
    pay_full = snap.count - IDX_W'(hdr_len);

    mid_res_next.source_address  = snap.addresses[63:32];
    mid_res_next.dest_address    = snap.addresses[31:0];
    mid_res_next.source_port     = snap.hdr0[63:48];
    mid_res_next.dest_port       = snap.hdr0[47:32];
    mid_res_next.sequence_number = snap.hdr0[31:0];
    mid_res_next.ack_number      = snap.hdr1[63:32];
    mid_res_next.header_words    = hw;
    mid_res_next.control_bits    = {snap.hdr1[24], snap.hdr1[23:16]};
    mid_res_next.window_size     = snap.hdr1[15:0];
    mid_res_next.urgent_pointer  = snap.urgent;
    mid_res_next.payload_length  = '0;
    mid_res_next.status          = itrc_pkg::ST_OK;
    mid_check_next               = 1'b0;

    mid_addr_sum_next = 18'(snap.addresses[63:48]) + 18'(snap.addresses[47:32]) +
                        18'(snap.addresses[31:16]) + 18'(snap.addresses[15:0]);
    mid_seg_len_next  = snap.count - IDX_W'(hl);

    if (snap.too_long) begin
      mid_res_next.status = itrc_pkg::ST_TOO_LONG;
    end else if (32'(snap.count) < itrc_pkg::MIN_PACKET) begin
      mid_res_next.status = itrc_pkg::ST_SHORT;
    end else if (!snap.version_ok) begin
      mid_res_next.status = itrc_pkg::ST_NOT_IPV4;
    end else if (!snap.protocol_ok) begin
      mid_res_next.status = itrc_pkg::ST_NOT_TCP;
    end else if (hw < 4'(itrc_pkg::MIN_HDR_WORDS) ||
                 32'(snap.count) < 32'(hdr_len)) begin
      mid_res_next.status = itrc_pkg::ST_SHORT;
    end else begin
      if (32'(pay_full) > itrc_pkg::PAY_MAX) begin
        mid_res_next.payload_length = itrc_pkg::PAY_W'(itrc_pkg::PAY_MAX);
      end else begin
        mid_res_next.payload_length = itrc_pkg::PAY_W'(pay_full);
      end
      if (snap.ip_sum != itrc_pkg::SUM_ALL_ONES) begin
        mid_res_next.status = itrc_pkg::ST_BAD_IP_SUM;
      end else begin
        mid_check_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      mid_valid <= 1'b1;
    end else if (out_ready) begin
      mid_valid <= 1'b0;
    end
    if (snap_valid && snap_ready) begin
      mid_res      <= mid_res_next;
      mid_check    <= mid_check_next;
      mid_addr_sum <= mid_addr_sum_next;
      mid_seg_len  <= mid_seg_len_next;
      mid_tcp_sum  <= snap.tcp_sum;
    end
  end

  // Second half: pseudo-header sum, end-around carry fold, final status
  always_comb begin
    total = 20'(mid_tcp_sum) + 20'(mid_addr_sum) + 20'(itrc_pkg::TCP_PROTO) +
            20'(mid_seg_len);
    fold1 = 17'(total[15:0]) + 17'(total[19:16]);
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    res_next = mid_res;
    if (mid_check) begin
      res_next.status = (fold2 == itrc_pkg::SUM_ALL_ONES) ? itrc_pkg::ST_OK
                                                          : itrc_pkg::ST_BAD_TCP_SUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (mid_valid && out_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (mid_valid && out_ready) begin
      res <= res_next;
    end
  end

endmodule

[rtl/ipv4_tcp_receive_checker.sv]
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: data_byte; s_tlast: last_byte
// m_*      out  m_tvalid/m_tready  m_tdata: packet fields and status, one item per packet
//
// One byte is taken per cycle, back to back, unless a last byte holds as described
// below. A packet's result passes from the input register through per-byte capture
// and sum, length checks and address sum, and the pseudo-header fold into the output
// register. Reset clears all packet state and empties every stage. While
// the output is stalled, bytes other than the last still drain; a last byte
// holds only when every result stage is full.
module ipv4_tcp_receive_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [2:0] status, [34:3] source_address, [66:35] dest_address,
  // [82:67] source_port, [98:83] dest_port, [130:99] sequence_number,
  // [162:131] ack_number, [166:163] header_words, [175:167] control_bits,
  // [191:176] window_size, [207:192] urgent_pointer, [219:208] payload_length,
  // [223:220] zero
  output logic [223:0] m_tdata
);

  logic            snap_valid;
  logic            snap_ready;
  itrc_pkg::snap_t snap;
  itrc_pkg::res_t  res;

  itrc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  itrc_verify u_verify (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .res        (res)
  );

  assign m_tdata = {4'b0000, res.payload_length, res.urgent_pointer, res.window_size,
                    res.control_bits, res.header_words, res.ack_number,
                    res.sequence_number, res.dest_port, res.source_port,
                    res.dest_address, res.source_address, 3'(res.status)};

endmodule

[tb/ipv4_tcp_receive_checker_tb.sv]
`timescale 1ns / 100ps

module ipv4_tcp_receive_checker_tb;
  import itrc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 600;
  localparam int RANDOM_BYTES = 1650;
  localparam int DRAIN_CYCLES = 16;
  localparam int UDP_PROTO    = 17;
  localparam int IPV6_VERSION = 6;

  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;
  typedef enum {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_RARE_STALL} rx_mode_t;

  typedef struct {
    int unsigned version;
    int unsigned ihl;
    int unsigned proto;
    int unsigned off;
    int unsigned pay;
    int unsigned total;     // 0 keeps the natural length, else cut to this many bytes
    bit          bad_ip;
    bit          bad_tcp;
    fill_t       fill;
    bit          typed;     // status below is known up front
    status_t     st;
  } pkt_spec_t;

  typedef logic [7:0] bytes_t[$];

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [223:0] m_tdata;

  ipv4_tcp_receive_checker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Packet state of the predictor
  logic [12:0] pk_count;
  logic [3:0]  pk_ihl;
  logic [15:0] pk_ip_sum;
  logic [15:0] pk_tcp_sum;
  logic        pk_ver_ok;
  logic        pk_proto_ok;
  logic        pk_overflow;
  logic [63:0] pk_addr;
  logic [63:0] pk_hdr0;
  logic [63:0] pk_hdr1;
  logic [15:0] pk_urgent;

  res_t        expected_results[$];
  pkt_spec_t   directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  res_t        seen_res;
  res_t        want_res;

  function automatic logic [15:0] ones_add(logic [15:0] s, logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  task automatic clear_packet();
    pk_count    = '0;
    pk_ihl      = '0;
    pk_ip_sum   = '0;
    pk_tcp_sum  = '0;
    pk_ver_ok   = 1'b0;
    pk_proto_ok = 1'b0;
    pk_overflow = 1'b0;
    pk_addr     = '0;
    pk_hdr0     = '0;
    pk_hdr1     = '0;
    pk_urgent   = '0;
  endtask

  // Take one byte into the packet state; on the last byte queue the result
  task automatic absorb_byte(input logic [7:0] b, input logic fin, input bit typed,
                             input status_t typed_st);
    int unsigned idx, hl, tl, r, pay;
    logic [15:0] w, t;
    logic [3:0]  hw;
    status_t     st;
    res_t        want;
    if (pk_count >= MAX_PACKET_BYTES) begin
      pk_overflow = 1'b1;
    end else begin
      idx = pk_count;
      if (idx == OFS_VER_IHL) begin
        pk_ihl    = b[3:0];
        pk_ver_ok = (b[7:4] == IP_VERSION) && (b[3:0] >= MIN_HDR_WORDS);
      end
      if (idx == OFS_PROTOCOL) pk_proto_ok = (b == TCP_PROTO);
      if (idx >= OFS_ADDR_LO && idx <= OFS_ADDR_END) pk_addr[(OFS_ADDR_END - idx) * 8 +: 8] = b;
      hl = pk_ihl * 4;
      w  = idx[0] ? {8'd0, b} : {b, 8'd0};
      if (idx < hl) begin
        pk_ip_sum = ones_add(pk_ip_sum, w);
      end else begin
        pk_tcp_sum = ones_add(pk_tcp_sum, w);
        r = idx - hl;
        if (r < TCP_HDR0_END) pk_hdr0[(TCP_HDR0_END - 1 - r) * 8 +: 8] = b;
        else if (r < TCP_HDR1_END) pk_hdr1[(TCP_HDR1_END - 1 - r) * 8 +: 8] = b;
        else if (r == TCP_URG_HI || r == TCP_URG_LO) pk_urgent[(TCP_URG_LO - r) * 8 +: 8] = b;
      end
      pk_count = pk_count + 1'b1;
    end
    if (fin) begin
      hl  = pk_ihl * 4;
      hw  = pk_hdr1[31:28];
      tl  = hw * 4;
      pay = 0;
      if (pk_overflow) st = ST_TOO_LONG;
      else if (pk_count < MIN_PACKET) st = ST_SHORT;
      else if (!pk_ver_ok) st = ST_NOT_IPV4;
      else if (!pk_proto_ok) st = ST_NOT_TCP;
      else if (hw < MIN_HDR_WORDS || pk_count < hl + tl) st = ST_SHORT;
      else begin
        pay = pk_count - hl - tl;
        if (pay > PAY_MAX) pay = PAY_MAX;
        if (pk_ip_sum != SUM_ALL_ONES) begin
          st = ST_BAD_IP_SUM;
        end else begin
          // fold in the pseudo-header
          t = ones_add(pk_tcp_sum, pk_addr[63:48]);
          t = ones_add(t, pk_addr[47:32]);
          t = ones_add(t, pk_addr[31:16]);
          t = ones_add(t, pk_addr[15:0]);
          t = ones_add(t, 16'(TCP_PROTO));
          t = ones_add(t, 16'(pk_count - hl));
          st = (t == SUM_ALL_ONES) ? ST_OK : ST_BAD_TCP_SUM;
        end
      end
      want.status          = typed ? typed_st : st;
      want.source_address  = pk_addr[63:32];
      want.dest_address    = pk_addr[31:0];
      want.source_port     = pk_hdr0[63:48];
      want.dest_port       = pk_hdr0[47:32];
      want.sequence_number = pk_hdr0[31:0];
      want.ack_number      = pk_hdr1[63:32];
      want.header_words    = hw;
      want.control_bits    = {pk_hdr1[24], pk_hdr1[23:16]};
      want.window_size     = pk_hdr1[15:0];
      want.urgent_pointer  = pk_urgent;
      want.payload_length  = PAY_W'(pay);
      expected_results.push_back(want);
      clear_packet();
    end
  endtask

  function automatic int unsigned natural_length(pkt_spec_t sp);
    int unsigned hlw, tlw;
    hlw = (sp.ihl < MIN_HDR_WORDS) ? MIN_HDR_WORDS : sp.ihl;
    tlw = (sp.off < MIN_HDR_WORDS) ? MIN_HDR_WORDS : sp.off;
    return (hlw + tlw) * 4 + sp.pay;
  endfunction

  task automatic build_packet(input pkt_spec_t sp, output bytes_t pk);
    int unsigned hlb, n, i;
    logic [15:0] s;
    hlb = ((sp.ihl < MIN_HDR_WORDS) ? MIN_HDR_WORDS : sp.ihl) * 4;
    n   = natural_length(sp);
    pk  = {};
    for (i = 0; i < n; i++) begin
      case (sp.fill)
        FILL_ONES:  pk.push_back(8'hFF);
        FILL_ZEROS: pk.push_back(8'h00);
        default:    pk.push_back(8'($urandom));
      endcase
    end
    pk[0]  = {4'(sp.version), 4'(sp.ihl)};
    pk[2]  = 8'(n >> 8);
    pk[3]  = 8'(n);
    pk[9]  = 8'(sp.proto);
    pk[10] = 8'd0;
    pk[11] = 8'd0;
    pk[hlb + 12] = {4'(sp.off), pk[hlb + 12][3:0]};
    pk[hlb + 16] = 8'd0;
    pk[hlb + 17] = 8'd0;
    s = '0;
    for (i = 0; i < hlb; i++) s = ones_add(s, i[0] ? {8'd0, pk[i]} : {pk[i], 8'd0});
    s = ~s;
    pk[10] = s[15:8];
    pk[11] = s[7:0];
    s = '0;
    for (i = hlb; i < n; i++) s = ones_add(s, i[0] ? {8'd0, pk[i]} : {pk[i], 8'd0});
    s = ones_add(s, {pk[12], pk[13]});
    s = ones_add(s, {pk[14], pk[15]});
    s = ones_add(s, {pk[16], pk[17]});
    s = ones_add(s, {pk[18], pk[19]});
    s = ones_add(s, 16'(TCP_PROTO));
    s = ones_add(s, 16'(n - hlb));
    s = ~s;
    pk[hlb + 16] = s[15:8];
    pk[hlb + 17] = s[7:0];
    if (sp.bad_ip) pk[10] ^= 8'h01;
    if (sp.bad_tcp) pk[hlb + 17] ^= 8'h01;
    if (sp.total != 0) begin
      while (pk.size() > sp.total) void'(pk.pop_back());
    end
  endtask

  task automatic add_row(int unsigned version, int unsigned ihl, int unsigned proto,
                         int unsigned off, int unsigned pay, int unsigned total, bit bad_ip,
                         bit bad_tcp, fill_t fill, bit typed, status_t st);
    pkt_spec_t sp;
    sp.version = version;
    sp.ihl     = ihl;
    sp.proto   = proto;
    sp.off     = off;
    sp.pay     = pay;
    sp.total   = total;
    sp.bad_ip  = bad_ip;
    sp.bad_tcp = bad_tcp;
    sp.fill    = fill;
    sp.typed   = typed;
    sp.st      = st;
    directed_rows.push_back(sp);
  endtask

  function automatic pkt_spec_t random_spec();
    pkt_spec_t sp;
    sp.version = IP_VERSION;
    sp.ihl     = MIN_HDR_WORDS;
    sp.proto   = TCP_PROTO;
    sp.off     = MIN_HDR_WORDS;
    sp.pay     = $urandom_range(0, 24);
    sp.total   = 0;
    sp.bad_ip  = 1'b0;
    sp.bad_tcp = 1'b0;
    sp.fill    = ($urandom_range(0, 19) == 0) ? FILL_ONES : FILL_RANDOM;
    sp.typed   = 1'b0;
    sp.st      = ST_OK;
    if ($urandom_range(0, 3) == 0) sp.ihl = $urandom_range(5, 15);
    if ($urandom_range(0, 3) == 0) sp.off = $urandom_range(5, 15);
    if ($urandom_range(0, 11) == 0) sp.pay = $urandom_range(25, 400);
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 8))
        0: begin
          do sp.version = $urandom_range(0, 15); while (sp.version == IP_VERSION);
        end
        1: sp.ihl = $urandom_range(0, 4);
        2: begin
          do sp.proto = $urandom_range(0, 255); while (sp.proto == TCP_PROTO);
        end
        3: sp.off = $urandom_range(0, 4);
        4: sp.total = $urandom_range(1, natural_length(sp) - 1);
        5: sp.bad_ip = 1'b1;
        6: sp.bad_tcp = 1'b1;
        7: sp.total = $urandom_range(1, MIN_PACKET - 1);
        default: begin
          sp.bad_ip  = 1'b1;
          sp.bad_tcp = 1'b1;
        end
      endcase
    end
    return sp;
  endfunction

  // Offer the bytes in bursts with random gaps, predicting on each accept
  task automatic send_packet(input bytes_t pk, input bit typed, input status_t st);
    int unsigned i;
    for (i = 0; i < pk.size(); i++) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 40);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= pk[i];
      s_tlast  <= (i == pk.size() - 1);
      do @(posedge clk); while (!s_tready);
      absorb_byte(pk[i], i == pk.size() - 1, typed, st);
      burst_left--;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic res_t from_bus(logic [223:0] d);
    res_t r;
    r.status          = status_t'(d[2:0]);
    r.source_address  = d[34:3];
    r.dest_address    = d[66:35];
    r.source_port     = d[82:67];
    r.dest_port       = d[98:83];
    r.sequence_number = d[130:99];
    r.ack_number      = d[162:131];
    r.header_words    = d[166:163];
    r.control_bits    = d[175:167];
    r.window_size     = d[191:176];
    r.urgent_pointer  = d[207:192];
    r.payload_length  = d[219:208];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_res = from_bus(m_tdata);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(seen_res.status), 32'd0);
      end else begin
        want_res = expected_results.pop_front();
        if (seen_res.status !== want_res.status)
          report_mismatch("status", 32'(seen_res.status), 32'(want_res.status));
        if (seen_res.source_address !== want_res.source_address)
          report_mismatch("source_address", seen_res.source_address, want_res.source_address);
        if (seen_res.dest_address !== want_res.dest_address)
          report_mismatch("dest_address", seen_res.dest_address, want_res.dest_address);
        if (seen_res.source_port !== want_res.source_port)
          report_mismatch("source_port", 32'(seen_res.source_port), 32'(want_res.source_port));
        if (seen_res.dest_port !== want_res.dest_port)
          report_mismatch("dest_port", 32'(seen_res.dest_port), 32'(want_res.dest_port));
        if (seen_res.sequence_number !== want_res.sequence_number)
          report_mismatch("sequence_number", seen_res.sequence_number,
                          want_res.sequence_number);
        if (seen_res.ack_number !== want_res.ack_number)
          report_mismatch("ack_number", seen_res.ack_number, want_res.ack_number);
        if (seen_res.header_words !== want_res.header_words)
          report_mismatch("header_words", 32'(seen_res.header_words),
                          32'(want_res.header_words));
        if (seen_res.control_bits !== want_res.control_bits)
          report_mismatch("control_bits", 32'(seen_res.control_bits),
                          32'(want_res.control_bits));
        if (seen_res.window_size !== want_res.window_size)
          report_mismatch("window_size", 32'(seen_res.window_size), 32'(want_res.window_size));
        if (seen_res.urgent_pointer !== want_res.urgent_pointer)
          report_mismatch("urgent_pointer", 32'(seen_res.urgent_pointer),
                          32'(want_res.urgent_pointer));
        if (seen_res.payload_length !== want_res.payload_length)
          report_mismatch("payload_length", 32'(seen_res.payload_length),
                          32'(want_res.payload_length));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ipv4_tcp_receive_checker_tb failed");
      $finish;
    end
  end

  // Result side: stall patterns in segments, one long hold-off on request
  initial begin : receiver
    int unsigned seg, i;
    rx_mode_t    mode;
    wait (!rst);
    forever begin
      if (hold_request && !hold_done) begin
        for (i = 0; i < LONG_HOLD; i++) begin
          @(posedge clk);
          m_tready <= 1'b0;
        end
        hold_done = 1'b1;
      end
      seg  = $urandom_range(16, 160);
      mode = rx_mode_t'($urandom_range(0, 3));
      for (i = 0; i < seg; i++) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:         m_tready <= 1'b1;
          RX_COIN:         m_tready <= 1'($urandom_range(0, 1));
          RX_EVERY_FOURTH: m_tready <= (i % 4 == 3);
          default:         m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : sender
    bytes_t      pk;
    pkt_spec_t   sp;
    int unsigned row, random_bytes;
    clear_packet();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_row(IP_VERSION, 5, TCP_PROTO, 5, 0, 1, 0, 0, FILL_RANDOM, 1, ST_SHORT);
    add_row(IP_VERSION, 5, TCP_PROTO, 5, 0, 39, 0, 0, FILL_RANDOM, 1, ST_SHORT);
    add_row(IP_VERSION, 5, TCP_PROTO, 5, 0, 0, 0, 0, FILL_RANDOM, 1, ST_OK);
    add_row(IPV6_VERSION, 5, TCP_PROTO, 5, 4, 0, 0, 0, FILL_RANDOM, 1, ST_NOT_IPV4);
    add_row(IP_VERSION, 4, TCP_PROTO, 5, 4, 0, 0, 0, FILL_RANDOM, 1, ST_NOT_IPV4);
    add_row(IP_VERSION, 0, TCP_PROTO, 5, 4, 0, 0, 0, FILL_RANDOM, 1, ST_NOT_IPV4);
    add_row(IP_VERSION, 5, UDP_PROTO, 5, 4, 0, 0, 0, FILL_RANDOM, 1, ST_NOT_TCP);
    add_row(IP_VERSION, 5, TCP_PROTO, 4, 4, 0, 0, 0, FILL_RANDOM, 1, ST_SHORT);
    // offset claims 60 header bytes but the packet stops at 40
    add_row(IP_VERSION, 5, TCP_PROTO, 15, 0, 40, 0, 0, FILL_RANDOM, 1, ST_SHORT);
    add_row(IP_VERSION, 5, TCP_PROTO, 5, 8, 0, 1, 0, FILL_RANDOM, 1, ST_BAD_IP_SUM);
    add_row(IP_VERSION, 5, TCP_PROTO, 5, 8, 0, 0, 1, FILL_RANDOM, 1, ST_BAD_TCP_SUM);
    add_row(IP_VERSION, 5, TCP_PROTO, 5, 7, 0, 0, 0, FILL_RANDOM, 0, ST_OK);
    add_row(IP_VERSION, 15, TCP_PROTO, 15, 13, 0, 0, 0, FILL_RANDOM, 0, ST_OK);
    add_row(IP_VERSION, 5, TCP_PROTO, 15, 3, 0, 0, 0, FILL_ONES, 0, ST_OK);
    add_row(IP_VERSION, 5, TCP_PROTO, 5, 5, 0, 0, 0, FILL_ZEROS, 0, ST_OK);
    add_row(IP_VERSION, 5, TCP_PROTO, 5, 4056, 0, 0, 0, FILL_RANDOM, 0, ST_OK);
    add_row(IP_VERSION, 5, TCP_PROTO, 5, 4057, 0, 0, 0, FILL_RANDOM, 1, ST_TOO_LONG);
    add_row(IP_VERSION, 5, TCP_PROTO, 5, 0, 0, 0, 0, FILL_RANDOM, 1, ST_OK);

    for (row = 0; row < directed_rows.size(); row++) begin
      build_packet(directed_rows[row], pk);
      send_packet(pk, directed_rows[row].typed, directed_rows[row].st);
    end

    // let the result side hold off while small packets keep coming
    hold_request = 1'b1;
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      sp = random_spec();
      build_packet(sp, pk);
      send_packet(pk, 1'b0, ST_OK);
      random_bytes += pk.size();
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ipv4_tcp_receive_checker_tb passed");
    end else begin
      $display("ipv4_tcp_receive_checker_tb failed");
    end
    $finish;
  end

endmodule
